>>> hw/rtl/jan_pkg.sv
package jan_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 14;
  localparam int OUT_W       = 16;

  // One stage prepares the operands, then one stage per quotient bit.
  localparam int NSTAGE      = FRAC_BITS + 1;
  localparam int MAG_W       = FRAC_BITS + 1;
  localparam int WIDE_W      = ((MAG_W > OUT_W) ? MAG_W : OUT_W) + 1;

  localparam int CFG_IDX_W   = 3;

  localparam logic [SAMPLE_BITS-1:0] CENTER_RST = SAMPLE_BITS'(2048);
  localparam logic [SAMPLE_BITS-1:0] MAX_RST    = SAMPLE_BITS'(4095);
  localparam logic [MAG_W-1:0]       MAG_ONE    = MAG_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN     = 3'd0,
    REG_X_CENTER  = 3'd1,
    REG_X_MAX     = 3'd2,
    REG_X_REVERSE = 3'd3,
    REG_Y_MIN     = 3'd4,
    REG_Y_CENTER  = 3'd5,
    REG_Y_MAX     = 3'd6,
    REG_Y_REVERSE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] min;
    logic [SAMPLE_BITS-1:0] center;
    logic [SAMPLE_BITS-1:0] max;
    logic                   reverse;
  } cal_t;

  typedef struct packed {
    logic force_zero;
    logic force_one;
    logic sign;
  } ctl_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
  } res_t;

endpackage

>>> hw/rtl/joystick_axis_normalizer_top.sv
// An accepted input word moves through the operand stage, the quotient stages and
// the output register. Throughput: one word per cycle while the skid register is
// empty; each axis lane holds a divider with one stage per quotient bit (14 stages)
// after one operand stage.
// Reset (rst_n, synchronous, active low) empties the pipeline and the output
// and skid registers, and sets every axis to min 0, center 2048, max 4095, not reversed.
module joystick_axis_normalizer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [jan_pkg::SAMPLE_BITS-1:0]     in_raw_x,
  input  logic [jan_pkg::SAMPLE_BITS-1:0]     in_raw_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [jan_pkg::OUT_W-1:0]    out_norm_x,
  output logic signed [jan_pkg::OUT_W-1:0]    out_norm_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jan_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jan_pkg::SAMPLE_BITS-1:0]     cfg_data
);

  jan_pkg::cal_t cal_x_r;
  jan_pkg::cal_t cal_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_x_r <= '{min: '0, center: jan_pkg::CENTER_RST, max: jan_pkg::MAX_RST,
                   reverse: 1'b0};
      cal_y_r <= '{min: '0, center: jan_pkg::CENTER_RST, max: jan_pkg::MAX_RST,
                   reverse: 1'b0};
    end else if (cfg_valid) begin
      case (jan_pkg::reg_idx_t'(cfg_index))
        jan_pkg::REG_X_MIN:     cal_x_r.min     <= cfg_data;
        jan_pkg::REG_X_CENTER:  cal_x_r.center  <= cfg_data;
        jan_pkg::REG_X_MAX:     cal_x_r.max     <= cfg_data;
        jan_pkg::REG_X_REVERSE: cal_x_r.reverse <= cfg_data[0];
        jan_pkg::REG_Y_MIN:     cal_y_r.min     <= cfg_data;
        jan_pkg::REG_Y_CENTER:  cal_y_r.center  <= cfg_data;
        jan_pkg::REG_Y_MAX:     cal_y_r.max     <= cfg_data;
        jan_pkg::REG_Y_REVERSE: cal_y_r.reverse <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  logic                         skid_full;
  logic                         adv;
  logic [jan_pkg::NSTAGE-1:0]   vld_r;

  // The whole pipeline moves only while the skid register is free.
  assign adv      = !skid_full;
  assign in_stall = skid_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[jan_pkg::NSTAGE-2:0], in_valid};
    end
  end

  logic signed [jan_pkg::OUT_W-1:0] lane_x;
  logic signed [jan_pkg::OUT_W-1:0] lane_y;
  jan_pkg::res_t                    out_res;

  jan_lane u_lane_x (
    .clk  (clk),
    .adv  (adv),
    .raw  (in_raw_x),
    .cal  (cal_x_r),
    .norm (lane_x)
  );

  jan_lane u_lane_y (
    .clk  (clk),
    .adv  (adv),
    .raw  (in_raw_y),
    .cal  (cal_y_r),
    .norm (lane_y)
  );

  jan_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_valid (vld_r[jan_pkg::NSTAGE-1]),
    .lane_x     (lane_x),
    .lane_y     (lane_y),
    .skid_full  (skid_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_norm_x = out_res.norm_x;
  assign out_norm_y = out_res.norm_y;

endmodule

>>> hw/rtl/jan_lane.sv
module jan_lane (
  input  logic                              clk,
  input  logic                              adv,
  input  logic [jan_pkg::SAMPLE_BITS-1:0]   raw,
  input  jan_pkg::cal_t                     cal,
  output logic signed [jan_pkg::OUT_W-1:0]  norm
);

  localparam int SB = jan_pkg::SAMPLE_BITS;
  localparam int FB = jan_pkg::FRAC_BITS;

  logic [SB-1:0]   rem_r [0:FB];
  logic [SB-1:0]   as_r  [0:FB];
  logic [FB-1:0]   q_r   [0:FB];
  jan_pkg::ctl_t   ctl_r [0:FB];

  // Operand preparation and the special cases.
  logic            upper;
  logic [SB-1:0]   d_nxt;
  logic [SB:0]     span;
  logic [SB:0]     span_abs;
  logic [SB-1:0]   as_nxt;
  logic [SB+3:0]   d10;
  logic            d_zero;
  logic            as_zero;
  jan_pkg::ctl_t   ctl_nxt;

  always_comb begin
    upper    = (raw >= cal.center);
    d_nxt    = upper ? (raw - cal.center) : (cal.center - raw);
    span     = upper ? ({1'b0, cal.max} - {1'b0, cal.center})
                     : ({1'b0, cal.center} - {1'b0, cal.min});
    span_abs = span[SB] ? (~span + 1'b1) : span;
    as_nxt   = span_abs[SB-1:0];
    d10      = {1'b0, d_nxt, 3'b000} + {3'b000, d_nxt, 1'b0};
    d_zero   = (d_nxt == '0);
    as_zero  = (as_nxt == '0);
    ctl_nxt.force_zero = d_zero || (!as_zero && (d10 < {4'b0000, as_nxt}));
    ctl_nxt.force_one  = !d_zero && (as_zero || (d_nxt >= as_nxt));
    // Lower side counts negative for a positive span; reverse flips once more.
    ctl_nxt.sign       = (upper ? span[SB] : !span[SB]) ^ cal.reverse;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= d_nxt;
      as_r[0]  <= as_nxt;
      q_r[0]   <= '0;
      ctl_r[0] <= ctl_nxt;
    end
  end

  // Restoring division, one quotient bit per stage. The remainder stays
  // below the divisor whenever the quotient is actually used.
  for (genvar k = 1; k <= FB; k++) begin : g_div
    logic [SB:0]   rem2;
    logic [SB:0]   diff;
    logic          ge;
    logic [SB-1:0] rem_nxt;
    logic [FB-1:0] q_nxt;

    always_comb begin
      rem2    = {rem_r[k-1], 1'b0};
      diff    = rem2 - {1'b0, as_r[k-1]};
      ge      = (rem2 >= {1'b0, as_r[k-1]});
      rem_nxt = ge ? diff[SB-1:0] : rem2[SB-1:0];
      q_nxt   = {q_r[k-1][FB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= rem_nxt;
        as_r[k]  <= as_r[k-1];
        q_r[k]   <= q_nxt;
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  logic [jan_pkg::MAG_W-1:0]         mag;
  logic signed [jan_pkg::WIDE_W-1:0] wide;

  always_comb begin
    if (ctl_r[FB].force_one) begin
      mag = jan_pkg::MAG_ONE;
    end else if (ctl_r[FB].force_zero) begin
      mag = '0;
    end else begin
      mag = {1'b0, q_r[FB]};
    end
    wide = signed'({{(jan_pkg::WIDE_W - jan_pkg::MAG_W){1'b0}}, mag});
    if (ctl_r[FB].sign) begin
      wide = -wide;
    end
    norm = wide[jan_pkg::OUT_W-1:0];
  end

endmodule

>>> hw/rtl/jan_merge.sv
module jan_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pipe_valid,
  input  logic signed [jan_pkg::OUT_W-1:0]  lane_x,
  input  logic signed [jan_pkg::OUT_W-1:0]  lane_y,
  output logic                              skid_full,
  output logic                              out_valid,
  input  logic                              out_stall,
  output jan_pkg::res_t                     out_res
);

  logic          out_valid_r;
  logic          skid_full_r;
  jan_pkg::res_t out_res_r;
  jan_pkg::res_t skid_r;
  jan_pkg::res_t joined;
  logic          take;
  logic          push;

  always_comb begin
    joined.norm_x = lane_x;
    joined.norm_y = lane_y;
    take = out_valid_r && !out_stall;
    push = pipe_valid && !skid_full_r;
  end

  // The skid register catches a word that leaves the pipeline while the
  // output register is still held, so the stall towards the input is registered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (take) begin
        out_res_r   <= skid_r;
        skid_full_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_res_r   <= joined;
        out_valid_r <= 1'b1;
      end else begin
        skid_r      <= joined;
        skid_full_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign skid_full = skid_full_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> bench/joystick_axis_normalizer_checker.sv
`timescale 1ns / 100ps

module joystick_axis_normalizer_checker
  import jan_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        in_raw_x,
  input  logic [SAMPLE_BITS-1:0]        in_raw_y,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [OUT_W-1:0]       out_norm_x,
  input  logic signed [OUT_W-1:0]       out_norm_y,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [SAMPLE_BITS-1:0]        cfg_data,
  output int                            mismatches,
  output int                            pending
);

  cal_t cal_x_q;
  cal_t cal_y_q;
  res_t norm_expect_q[$];
  res_t norm_seen;
  res_t norm_want;

  // Maps one raw sample onto -1.0 .. +1.0 in Q1.14 for the given calibration.
  function automatic logic signed [OUT_W-1:0] normalize_axis(logic [SAMPLE_BITS-1:0] raw,
                                                             cal_t c);
    int delta;
    int span;
    int abs_span;
    int mag;
    int full;
    int res;
    bit negate;
    full = 1 << FRAC_BITS;
    if (raw >= c.center) begin
      delta  = int'(raw) - int'(c.center);
      span   = int'(c.max) - int'(c.center);
      negate = (span < 0);
    end else begin
      delta  = int'(c.center) - int'(raw);
      span   = int'(c.center) - int'(c.min);
      negate = (span >= 0);
    end
    abs_span = (span < 0) ? -span : span;
    if (delta == 0) begin
      mag = 0;
    end else if (abs_span == 0) begin
      mag = full;
    end else if (10 * delta < abs_span) begin
      mag = 0;
    end else begin
      mag = (delta << FRAC_BITS) / abs_span;
      if (mag > full) mag = full;
    end
    res = negate ? -mag : mag;
    if (c.reverse) res = -res;
    return OUT_W'(res);
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cal_x_q    = '{min: '0, center: CENTER_RST, max: MAX_RST, reverse: 1'b0};
      cal_y_q    = cal_x_q;
      norm_expect_q.delete();
      mismatches = 0;
    end else begin
      // A word accepted on the same edge as a register write still sees the old setting.
      if (in_valid && !in_stall) begin
        norm_want.norm_x = normalize_axis(in_raw_x, cal_x_q);
        norm_want.norm_y = normalize_axis(in_raw_y, cal_y_q);
        norm_expect_q.push_back(norm_want);
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_X_MIN:     cal_x_q.min     = cfg_data;
          REG_X_CENTER:  cal_x_q.center  = cfg_data;
          REG_X_MAX:     cal_x_q.max     = cfg_data;
          REG_X_REVERSE: cal_x_q.reverse = cfg_data[0];
          REG_Y_MIN:     cal_y_q.min     = cfg_data;
          REG_Y_CENTER:  cal_y_q.center  = cfg_data;
          REG_Y_MAX:     cal_y_q.max     = cfg_data;
          REG_Y_REVERSE: cal_y_q.reverse = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        norm_seen.norm_x = out_norm_x;
        norm_seen.norm_y = out_norm_y;
        if (norm_expect_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result word x=%0d y=%0d",
                                  norm_seen.norm_x, norm_seen.norm_y));
        end else begin
          norm_want = norm_expect_q.pop_front();
          if (norm_seen.norm_x !== norm_want.norm_x)
            note_mismatch($sformatf("norm_x expected %0d, got %0d",
                                    norm_want.norm_x, norm_seen.norm_x));
          if (norm_seen.norm_y !== norm_want.norm_y)
            note_mismatch($sformatf("norm_y expected %0d, got %0d",
                                    norm_want.norm_y, norm_seen.norm_y));
        end
      end
    end
    pending = norm_expect_q.size();
  end

endmodule

>>> bench/tb_joystick_axis_normalizer_top.sv
`timescale 1ns / 100ps

module tb_joystick_axis_normalizer_top;
  import jan_pkg::*;

  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_WORDS    = 150;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [SAMPLE_BITS-1:0]      in_raw_x = '0;
  logic [SAMPLE_BITS-1:0]      in_raw_y = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [OUT_W-1:0]     out_norm_x;
  logic signed [OUT_W-1:0]     out_norm_y;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [SAMPLE_BITS-1:0]      cfg_data = '0;
  int                          mismatches;
  int                          pending;

  int                          idle_cycles = 0;
  logic [15:0]                 stall_pattern = '0;
  int                          stall_slot = 0;
  cal_t                        cur_x;
  cal_t                        cur_y;
  int                          sent;
  int                          burst;

  always #5 clk = ~clk;

  joystick_axis_normalizer_top dut (.*);

  joystick_axis_normalizer_checker checker_i (.*);

  // The receiver stalls on a pattern of slots redrawn each window; one slot is
  // always left open so no stall outlasts two windows.
  always @(negedge clk) begin
    if (stall_slot == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = '0;
        1:       stall_pattern = 16'($urandom & $urandom);
        2:       stall_pattern = 16'($urandom);
        default: stall_pattern = 16'($urandom | $urandom);
      endcase
      stall_pattern[$urandom_range(15, 0)] = 1'b0;
    end
    out_stall <= stall_pattern[stall_slot];
    stall_slot = (stall_slot + 1) % 16;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("joystick_axis_normalizer_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic cal_t make_cal(int mn, int ctr, int mx, bit rev);
    cal_t c;
    c.min     = SAMPLE_BITS'(mn);
    c.center  = SAMPLE_BITS'(ctr);
    c.max     = SAMPLE_BITS'(mx);
    c.reverse = rev;
    return c;
  endfunction

  function automatic cal_t rand_cal();
    int ctr;
    ctr = $urandom_range(0, 4095);
    case ($urandom_range(0, 5))
      0: return make_cal($urandom_range(0, ctr), ctr, $urandom_range(ctr, 4095),
                         1'($urandom_range(0, 1)));
      1: return make_cal($urandom_range(ctr, 4095), ctr, $urandom_range(0, ctr),
                         1'($urandom_range(0, 1)));
      2: return make_cal($urandom_range(0, 4095), ctr, $urandom_range(0, 4095),
                         1'($urandom_range(0, 1)));
      // One side of the axis has no span at all.
      3: return $urandom_range(0, 1) ?
                make_cal(ctr, ctr, $urandom_range(0, 4095), 1'($urandom_range(0, 1))) :
                make_cal($urandom_range(0, 4095), ctr, ctr, 1'($urandom_range(0, 1)));
      4: return make_cal(0, 2048, 4095, 1'($urandom_range(0, 1)));
      default: return make_cal($urandom_range(0, 1) * 4095, $urandom_range(0, 1) * 4095,
                               $urandom_range(0, 1) * 4095, 1'($urandom_range(0, 1)));
    endcase
  endfunction

  // Four in ten samples sit near the centre so the dead-zone edge is crossed often.
  function automatic logic [SAMPLE_BITS-1:0] pick_raw(cal_t c);
    int choice;
    int v;
    choice = $urandom_range(0, 9);
    if (choice <= 3) begin
      v = $urandom_range(0, 4095);
    end else if (choice <= 7) begin
      v = int'(c.center) + int'($urandom_range(0, 600)) - 300;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
    end else if (choice == 8) begin
      case ($urandom_range(0, 2))
        0:       v = int'(c.min);
        1:       v = int'(c.center);
        default: v = int'(c.max);
      endcase
    end else begin
      v = $urandom_range(0, 1) ? 4095 : 0;
    end
    return SAMPLE_BITS'(v);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_sample(logic [SAMPLE_BITS-1:0] rx, logic [SAMPLE_BITS-1:0] ry);
    in_raw_x <= rx;
    in_raw_y <= ry;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [SAMPLE_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_cal(cal_t cx, cal_t cy);
    wait_idle();
    write_reg(REG_X_MIN, cx.min);
    write_reg(REG_X_CENTER, cx.center);
    write_reg(REG_X_MAX, cx.max);
    write_reg(REG_X_REVERSE, SAMPLE_BITS'(cx.reverse));
    write_reg(REG_Y_MIN, cy.min);
    write_reg(REG_Y_CENTER, cy.center);
    write_reg(REG_Y_MAX, cy.max);
    write_reg(REG_Y_REVERSE, {11'($urandom_range(0, 2047)), cy.reverse});
    cfg_valid <= 1'b0;
    @(negedge clk);
    cur_x = cx;
    cur_y = cy;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset calibration: full travel, centre, and both sides of the dead zone.
    send_sample(0, 4095);
    send_sample(4095, 0);
    send_sample(2048, 2048);
    send_sample(2252, 1844);
    send_sample(2253, 1843);
    send_sample(2047, 2049);

    // Narrow travel that saturates, reversed X, inverted Y calibration.
    apply_cal(make_cal(1000, 2000, 3000, 1'b1), make_cal(4000, 2000, 100, 1'b0));
    send_sample(4095, 0);
    send_sample(0, 4095);
    send_sample(2500, 2500);
    send_sample(1500, 1500);

    // No span on either side: full deflection, or zero when at the centre.
    apply_cal(make_cal(2000, 2000, 2000, 1'b0), make_cal(0, 0, 0, 1'b1));
    send_sample(2000, 0);
    send_sample(2001, 4095);
    send_sample(1999, 1);
    send_sample(0, 0);

    // Centre at either end of the range.
    apply_cal(make_cal(0, 4095, 4095, 1'b1), make_cal(4095, 0, 0, 1'b0));
    send_sample(4095, 0);
    send_sample(0, 4095);
    send_sample(4094, 1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_cal(rand_cal(), rand_cal());
      sent = 0;
      while (sent < PHASE_WORDS) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < PHASE_WORDS; k++) begin
          send_sample(pick_raw(cur_x), pick_raw(cur_y));
          sent++;
        end
        if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 8));
      end
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("joystick_axis_normalizer_top verification clean");
    end else begin
      $display("joystick_axis_normalizer_top verification failed");
    end
    $finish;
  end

endmodule
